// File: rtl/rerh_pkg.sv
// ----------------------------------------------------------------------------
// rerh_pkg: shared types and constants
// fixed-point widths, datapath micro-op codes, command/status bundles
// ----------------------------------------------------------------------------
`default_nettype none

package rerh_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  // exact geometry widths
  localparam int WW    = 67;   // den, tn, sn
  localparam int HALF  = 33;   // split point of wide operands
  localparam int MW    = 34;   // multiplier operand width
  localparam int ACC_W = 104;  // z accumulator
  localparam int DIV_W = 100;  // divider remainder / shifted divisor
  localparam int QW    = 32;

  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [CFG_IW-1:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [CFG_IW-1:0] REG_ORIGIN_Z     = 3'd2;
  localparam logic [CFG_IW-1:0] REG_CEIL_HEIGHT  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_VERTEX_COUNT = 3'd4;
  localparam logic [CFG_IW-1:0] REG_MIN_DISTANCE = 3'd5;

  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_CAST = 1'b1;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic [30:0]        ceil_height;
    logic [6:0]         vertex_count;
    logic [15:0]        min_distance;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_START,
    OP_FC_SETUP,
    OP_LATCH_A,
    OP_LATCH_B,
    OP_DEN1,
    OP_DEN2,
    OP_TN1,
    OP_TN2,
    OP_SN1,
    OP_SN2,
    OP_NORM,
    OP_Z1,
    OP_Z2,
    OP_Z3,
    OP_Z4,
    OP_Z5,
    OP_Z6,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_TAKE
  } dp_op_t;

  typedef struct packed {
    dp_op_t        op;
    logic [AW-1:0] addr;  // vertex table read address
    logic          sel;   // floor (0) or ceiling (1)
  } dp_cmd_t;

  typedef struct packed {
    logic dz_zero;
    logic den_zero;
    logic tn_pos;
    logic s_ok;
    logic z_ok;
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/rerh_ram.sv
// ----------------------------------------------------------------------------
// rerh_ram: generic single-port-write, single-port-read RAM
// registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module rerh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/rerh_datapath.sv
// ----------------------------------------------------------------------------
// rerh_datapath: vertex tables, shared multiplier, restoring divider
// executes one micro-op per cycle as commanded by the controller
// ----------------------------------------------------------------------------
`default_nettype none

module rerh_datapath (
  input  wire logic                     clk,
  input  wire rerh_pkg::cfg_t           cfg,
  input  wire rerh_pkg::dp_cmd_t        cmd,
  input  wire logic                     vtx_we,
  input  wire logic [5:0]               vtx_index,
  input  wire logic signed [31:0]       vtx_x,
  input  wire logic signed [31:0]       vtx_y,
  input  wire logic signed [31:0]       dir_x,
  input  wire logic signed [31:0]       dir_y,
  input  wire logic signed [31:0]       dir_z,
  output rerh_pkg::dp_status_t          status,
  output logic                          hit,
  output logic [rerh_pkg::QW-1:0]       best
);

  localparam int WW    = rerh_pkg::WW;
  localparam int HALF  = rerh_pkg::HALF;
  localparam int MW    = rerh_pkg::MW;
  localparam int ACC_W = rerh_pkg::ACC_W;
  localparam int DIV_W = rerh_pkg::DIV_W;
  localparam int QW    = rerh_pkg::QW;
  localparam int AW    = rerh_pkg::AW;

  logic [31:0] rd_x, rd_y;
  logic        wr_en;

  assign wr_en = vtx_we && (32'(vtx_index) < 32'(rerh_pkg::MAX_VERTICES));

  rerh_ram #(.WIDTH(32), .DEPTH(rerh_pkg::MAX_VERTICES)) u_ram_x (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(vtx_index)),
    .wdata (vtx_x),
    .raddr (cmd.addr),
    .rdata (rd_x)
  );

  rerh_ram #(.WIDTH(32), .DEPTH(rerh_pkg::MAX_VERTICES)) u_ram_y (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(vtx_index)),
    .wdata (vtx_y),
    .raddr (cmd.addr),
    .rdata (rd_y)
  );

  logic signed [31:0]    dx_r, dy_r, dz_r, ax_r, ay_r;
  logic signed [32:0]    ex_r, ey_r, rx_r, ry_r;
  logic signed [WW-1:0]  den_r, tn_r, sn_r;
  logic signed [ACC_W-1:0] acc_r, zn_r;
  logic [DIV_W-1:0]      rem_r, dsh_r;
  logic [QW-1:0]         q_r, best_r;
  logic                  sat_r, ok_r;

  logic signed [MW-1:0]    mul_a, mul_b;
  logic signed [2*MW-1:0]  prod;
  logic signed [ACC_W-1:0] prod_ext, prod_sh;
  logic                    use_sh;

  logic signed [MW-1:0] den_lo, den_hi, tn_lo, tn_hi;

  assign den_lo = $signed({1'b0, den_r[HALF-1:0]});
  assign den_hi = $signed(den_r[WW-1:HALF]);
  assign tn_lo  = $signed({1'b0, tn_r[HALF-1:0]});
  assign tn_hi  = $signed(tn_r[WW-1:HALF]);

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    use_sh = 1'b0;
    case (cmd.op)
      rerh_pkg::OP_DEN1: begin mul_a = MW'(dx_r); mul_b = MW'(ey_r); end
      rerh_pkg::OP_DEN2: begin mul_a = MW'(dy_r); mul_b = MW'(ex_r); end
      rerh_pkg::OP_TN1:  begin mul_a = MW'(rx_r); mul_b = MW'(ey_r); end
      rerh_pkg::OP_TN2:  begin mul_a = MW'(ry_r); mul_b = MW'(ex_r); end
      rerh_pkg::OP_SN1:  begin mul_a = MW'(rx_r); mul_b = MW'(dy_r); end
      rerh_pkg::OP_SN2:  begin mul_a = MW'(ry_r); mul_b = MW'(dx_r); end
      rerh_pkg::OP_Z1:   begin mul_a = MW'(cfg.origin_z); mul_b = den_lo; end
      rerh_pkg::OP_Z2: begin
        mul_a = MW'(cfg.origin_z); mul_b = den_hi; use_sh = 1'b1;
      end
      rerh_pkg::OP_Z3:   begin mul_a = MW'(dz_r); mul_b = tn_lo; end
      rerh_pkg::OP_Z4: begin
        mul_a = MW'(dz_r); mul_b = tn_hi; use_sh = 1'b1;
      end
      rerh_pkg::OP_Z5:   begin mul_a = $signed({3'b000, cfg.ceil_height}); mul_b = den_lo; end
      rerh_pkg::OP_Z6: begin
        mul_a = $signed({3'b000, cfg.ceil_height}); mul_b = den_hi; use_sh = 1'b1;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_ext = ACC_W'(prod);
  assign prod_sh  = use_sh ? (prod_ext <<< HALF) : prod_ext;

  // floor / ceiling numerator and denominator
  logic signed [WW-1:0] fc_num, fc_num_n, dz_w;
  assign dz_w     = WW'(dz_r);
  assign fc_num   = cmd.sel ? (WW'($signed({1'b0, cfg.ceil_height})) - WW'(cfg.origin_z))
                            : -WW'(cfg.origin_z);
  assign fc_num_n = dz_r[31] ? -fc_num : fc_num;

  logic [DIV_W-1:0] n_sh, d_ext;
  assign n_sh  = DIV_W'($unsigned(tn_r)) << 16;
  assign d_ext = DIV_W'($unsigned(den_r));

  logic [QW-1:0] tq;
  assign tq = sat_r ? '1 : q_r;

  always_ff @(posedge clk) begin
    case (cmd.op)
      rerh_pkg::OP_START: begin
        dx_r   <= dir_x;
        dy_r   <= dir_y;
        dz_r   <= dir_z;
        ok_r   <= 1'b0;
        best_r <= '0;
      end
      rerh_pkg::OP_FC_SETUP: begin
        tn_r  <= fc_num_n;
        den_r <= dz_r[31] ? -dz_w : dz_w;
      end
      rerh_pkg::OP_LATCH_A: begin
        ax_r <= $signed(rd_x);
        ay_r <= $signed(rd_y);
      end
      rerh_pkg::OP_LATCH_B: begin
        ex_r <= 33'($signed(rd_x)) - 33'(ax_r);
        ey_r <= 33'($signed(rd_y)) - 33'(ay_r);
        rx_r <= 33'(ax_r) - 33'(cfg.origin_x);
        ry_r <= 33'(ay_r) - 33'(cfg.origin_y);
      end
      rerh_pkg::OP_DEN1, rerh_pkg::OP_TN1, rerh_pkg::OP_SN1,
      rerh_pkg::OP_Z1, rerh_pkg::OP_Z5: begin
        acc_r <= prod_sh;
      end
      rerh_pkg::OP_DEN2: den_r <= WW'(acc_r - prod_sh);
      rerh_pkg::OP_TN2:  tn_r  <= WW'(acc_r - prod_sh);
      rerh_pkg::OP_SN2:  sn_r  <= WW'(acc_r - prod_sh);
      rerh_pkg::OP_NORM: begin
        if (den_r[WW-1]) begin
          den_r <= -den_r;
          tn_r  <= -tn_r;
          sn_r  <= -sn_r;
        end
      end
      rerh_pkg::OP_Z2, rerh_pkg::OP_Z3, rerh_pkg::OP_Z6: begin
        acc_r <= acc_r + prod_sh;
      end
      rerh_pkg::OP_Z4: zn_r <= acc_r + prod_sh;
      rerh_pkg::OP_DIV_INIT: begin
        rem_r <= n_sh;
        dsh_r <= d_ext << 31;
        sat_r <= n_sh >= (d_ext << 32);
        q_r   <= '0;
      end
      rerh_pkg::OP_DIV_STEP: begin
        if (rem_r >= dsh_r) begin
          rem_r <= rem_r - dsh_r;
          q_r   <= {q_r[QW-2:0], 1'b1};
        end else begin
          q_r   <= {q_r[QW-2:0], 1'b0};
        end
        dsh_r <= dsh_r >> 1;
      end
      rerh_pkg::OP_TAKE: begin
        if ((tq > QW'(cfg.min_distance)) && (!ok_r || (tq < best_r))) begin
          best_r <= tq;
          ok_r   <= 1'b1;
        end
      end
      default: begin
        q_r <= q_r;
      end
    endcase
  end

  assign status.dz_zero  = (dz_r == '0);
  assign status.den_zero = (den_r == '0);
  assign status.tn_pos   = !tn_r[WW-1] && (tn_r != '0);
  assign status.s_ok     = !sn_r[WW-1] && (sn_r <= den_r);
  assign status.z_ok     = !zn_r[ACC_W-1] && (zn_r <= acc_r);

  assign hit  = ok_r;
  assign best = best_r;

endmodule

`default_nettype wire

// File: rtl/rerh_ctrl.sv
// ----------------------------------------------------------------------------
// rerh_ctrl: cast sequencer
// walks floor, ceiling and every wall edge, issuing datapath micro-ops
// ----------------------------------------------------------------------------
`default_nettype none

module rerh_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_action,
  input  wire logic [6:0]            vertex_count,
  input  wire logic                  out_free,
  input  wire rerh_pkg::dp_status_t  status,
  output logic                       in_ready,
  output logic                       emit,
  output rerh_pkg::dp_cmd_t          cmd
);

  localparam int CW = rerh_pkg::CW;
  localparam int AW = rerh_pkg::AW;

  typedef enum logic [4:0] {
    S_IDLE, S_FC_CHK, S_FC_SETUP, S_FC_TEST, S_FC_NEXT,
    S_DIV_INIT, S_DIV, S_TAKE,
    S_E_BEGIN, S_E_RD, S_E_LA, S_E_LB, S_E_DEN1, S_E_DEN2, S_E_DENCHK,
    S_E_TN1, S_E_TN2, S_E_SN1, S_E_SN2, S_E_NORM, S_E_SCHK,
    S_E_Z1, S_E_Z2, S_E_Z3, S_E_Z4, S_E_Z5, S_E_Z6, S_E_ZCHK,
    S_E_NEXT, S_DONE
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic          k_r, k_nxt, wall_r, wall_nxt;

  logic [CW-1:0] n_edges, i_inc, j_idx;

  assign n_edges = (32'(vertex_count) > 32'(rerh_pkg::MAX_VERTICES))
                   ? CW'(rerh_pkg::MAX_VERTICES) : CW'(vertex_count);
  assign i_inc   = i_r + CW'(1);
  assign j_idx   = (i_inc == n_edges) ? '0 : i_inc;

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    wall_nxt  = wall_r;
    cmd.op    = rerh_pkg::OP_NONE;
    cmd.addr  = i_r[AW-1:0];
    cmd.sel   = k_r;
    emit      = 1'b0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && (in_action == rerh_pkg::ACTION_CAST)) begin
          cmd.op    = rerh_pkg::OP_START;
          k_nxt     = 1'b0;
          wall_nxt  = 1'b0;
          state_nxt = S_FC_CHK;
        end
      end
      S_FC_CHK:   state_nxt = status.dz_zero ? S_E_BEGIN : S_FC_SETUP;
      S_FC_SETUP: begin
        cmd.op    = rerh_pkg::OP_FC_SETUP;
        state_nxt = S_FC_TEST;
      end
      S_FC_TEST:  state_nxt = status.tn_pos ? S_DIV_INIT : S_FC_NEXT;
      S_FC_NEXT: begin
        if (!k_r) begin
          k_nxt     = 1'b1;
          state_nxt = S_FC_SETUP;
        end else begin
          state_nxt = S_E_BEGIN;
        end
      end
      S_DIV_INIT: begin
        cmd.op    = rerh_pkg::OP_DIV_INIT;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op  = rerh_pkg::OP_DIV_STEP;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          state_nxt = S_TAKE;
        end
      end
      S_TAKE: begin
        cmd.op    = rerh_pkg::OP_TAKE;
        state_nxt = wall_r ? S_E_NEXT : S_FC_NEXT;
      end
      S_E_BEGIN: begin
        i_nxt     = '0;
        wall_nxt  = 1'b1;
        state_nxt = (n_edges == '0) ? S_DONE : S_E_RD;
      end
      S_E_RD:     state_nxt = S_E_LA;
      S_E_LA: begin
        cmd.op    = rerh_pkg::OP_LATCH_A;
        cmd.addr  = j_idx[AW-1:0];
        state_nxt = S_E_LB;
      end
      S_E_LB: begin
        cmd.op    = rerh_pkg::OP_LATCH_B;
        state_nxt = S_E_DEN1;
      end
      S_E_DEN1: begin cmd.op = rerh_pkg::OP_DEN1; state_nxt = S_E_DEN2; end
      S_E_DEN2: begin cmd.op = rerh_pkg::OP_DEN2; state_nxt = S_E_DENCHK; end
      S_E_DENCHK: state_nxt = status.den_zero ? S_E_NEXT : S_E_TN1;
      S_E_TN1:  begin cmd.op = rerh_pkg::OP_TN1;  state_nxt = S_E_TN2; end
      S_E_TN2:  begin cmd.op = rerh_pkg::OP_TN2;  state_nxt = S_E_SN1; end
      S_E_SN1:  begin cmd.op = rerh_pkg::OP_SN1;  state_nxt = S_E_SN2; end
      S_E_SN2:  begin cmd.op = rerh_pkg::OP_SN2;  state_nxt = S_E_NORM; end
      S_E_NORM: begin cmd.op = rerh_pkg::OP_NORM; state_nxt = S_E_SCHK; end
      S_E_SCHK: state_nxt = (status.tn_pos && status.s_ok) ? S_E_Z1 : S_E_NEXT;
      S_E_Z1:   begin cmd.op = rerh_pkg::OP_Z1; state_nxt = S_E_Z2; end
      S_E_Z2:   begin cmd.op = rerh_pkg::OP_Z2; state_nxt = S_E_Z3; end
      S_E_Z3:   begin cmd.op = rerh_pkg::OP_Z3; state_nxt = S_E_Z4; end
      S_E_Z4:   begin cmd.op = rerh_pkg::OP_Z4; state_nxt = S_E_Z5; end
      S_E_Z5:   begin cmd.op = rerh_pkg::OP_Z5; state_nxt = S_E_Z6; end
      S_E_Z6:   begin cmd.op = rerh_pkg::OP_Z6; state_nxt = S_E_ZCHK; end
      S_E_ZCHK: state_nxt = status.z_ok ? S_DIV_INIT : S_E_NEXT;
      S_E_NEXT: begin
        if (i_inc == n_edges) begin
          state_nxt = S_DONE;
        end else begin
          i_nxt     = i_inc;
          state_nxt = S_E_RD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      cnt_r   <= '0;
      k_r     <= 1'b0;
      wall_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
      wall_r  <= wall_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/room_envelope_ray_hit_unit.sv
// ----------------------------------------------------------------------------
// room_envelope_ray_hit_unit: nearest ray hit against an extruded polygon room
// floor, ceiling and vertical walls; exact integer geometry, Q16.16 distance
// ----------------------------------------------------------------------------
// A load transfer (in_action 0) writes one polygon vertex; it gives no
// result. A cast transfer (in_action 1) gives one result. A cast visits
// floor and ceiling when dir_z is nonzero, then every wall edge; an edge
// ends early when it is parallel to the ray, when the hit lies behind or
// outside the edge, or when it misses in height, and otherwise reaches the
// divider. The cast time is set by the single shared 34x34 multiplier, used
// once per cycle, and by the restoring divider that retires one quotient bit
// per cycle. The next cast is taken as soon as the current one has moved its
// result into the output register, and the output register may still wait
// for out_ready while the next cast runs. Vertex slots read by a cast must
// have been written; the vertex tables have no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module room_envelope_ray_hit_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration
  input  wire logic                              cfg_we,
  input  wire logic [rerh_pkg::CFG_IW-1:0]       cfg_index,
  input  wire logic [31:0]                       cfg_wdata,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_action,
  input  wire logic [5:0]                        in_vertex_index,
  input  wire logic signed [31:0]                in_vertex_x,
  input  wire logic signed [31:0]                in_vertex_y,
  input  wire logic signed [31:0]                in_dir_x,
  input  wire logic signed [31:0]                in_dir_y,
  input  wire logic signed [31:0]                in_dir_z,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_hit,
  output logic [31:0]                            out_distance
);

  // configuration registers
  rerh_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x     <= '0;
      cfg_r.origin_y     <= '0;
      cfg_r.origin_z     <= '0;
      cfg_r.ceil_height  <= 31'd65536;
      cfg_r.vertex_count <= '0;
      cfg_r.min_distance <= 16'd66;
    end else if (cfg_we) begin
      case (cfg_index)
        rerh_pkg::REG_ORIGIN_X:     cfg_r.origin_x     <= $signed(cfg_wdata);
        rerh_pkg::REG_ORIGIN_Y:     cfg_r.origin_y     <= $signed(cfg_wdata);
        rerh_pkg::REG_ORIGIN_Z:     cfg_r.origin_z     <= $signed(cfg_wdata);
        rerh_pkg::REG_CEIL_HEIGHT:  cfg_r.ceil_height  <= cfg_wdata[30:0];
        rerh_pkg::REG_VERTEX_COUNT: cfg_r.vertex_count <= cfg_wdata[6:0];
        rerh_pkg::REG_MIN_DISTANCE: cfg_r.min_distance <= cfg_wdata[15:0];
        default: cfg_r <= cfg_r;  // unmapped index, ignored
      endcase
    end
  end

  rerh_pkg::dp_cmd_t    cmd;
  rerh_pkg::dp_status_t status;
  logic                 emit, dp_hit, vtx_we, out_free;
  logic [31:0]          dp_best;

  // result register, decouples the sequencer from the consumer
  logic        out_valid_r;
  logic        out_hit_r;
  logic [31:0] out_distance_r;

  // vertex load happens on the transfer itself
  assign vtx_we   = in_valid && in_ready && (in_action == rerh_pkg::ACTION_LOAD);
  // output register free, or emptied in this cycle
  assign out_free = !out_valid_r || out_ready;

  rerh_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_action    (in_action),
    .vertex_count (cfg_r.vertex_count),
    .out_free     (out_free),
    .status       (status),
    .in_ready     (in_ready),
    .emit         (emit),
    .cmd          (cmd)
  );

  rerh_datapath u_dp (
    .clk       (clk),
    .cfg       (cfg_r),
    .cmd       (cmd),
    .vtx_we    (vtx_we),
    .vtx_index (in_vertex_index),
    .vtx_x     (in_vertex_x),
    .vtx_y     (in_vertex_y),
    .dir_x     (in_dir_x),
    .dir_y     (in_dir_y),
    .dir_z     (in_dir_z),
    .status    (status),
    .hit       (dp_hit),
    .best      (dp_best)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_hit_r      <= dp_hit;
      out_distance_r <= dp_hit ? dp_best : 32'd0;  // zero on a miss
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_distance = out_distance_r;

endmodule

`default_nettype wire
